// ----- sv/tdcc_pkg.sv -----
// Shared types and constants for the tick driven calendar clock.
// No dependencies; every other source file but tdcc_if imports this package.
package tdcc_pkg;

  localparam int TPS_W    = 20;  // tick period register width
  localparam int SYNC_W   = 12;  // sync_interval register width
  localparam int CFG_DW   = 20;  // widest configuration register
  localparam int CFG_IW   = 1;   // configuration index width
  localparam int UPTIME_W = 64;

  localparam logic [CFG_IW-1:0] REG_TICK_PERIOD   = 1'd0;
  localparam logic [CFG_IW-1:0] REG_SYNC_INTERVAL = 1'd1;

  localparam logic [TPS_W-1:0]  TPS_RESET  = 20'd1000;
  localparam logic [SYNC_W-1:0] SYNC_RESET = 12'd3600;

  localparam logic [6:0] SECS_PER_MIN  = 7'd60;
  localparam logic [6:0] MINS_PER_HOUR = 7'd60;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;
  localparam logic [4:0] MONTHS        = 5'd12;

  localparam logic [4:0] DAYS_31  = 5'd31;
  localparam logic [4:0] DAYS_30  = 5'd30;
  localparam logic [4:0] DAYS_29  = 5'd29;
  localparam logic [4:0] DAYS_28  = 5'd28;

  // multiples of 25 in 14 bits map onto 0..655 under multiply by 25^-1 mod 2^14
  localparam logic [13:0] INV25_MOD14 = 14'd7209;
  localparam logic [13:0] MULT25_MAX  = 14'd655;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } cal_t;

  localparam cal_t CAL_RESET = '{year: 14'd1970, month: 4'd1, day: 5'd1,
                                 hours: 5'd0, minutes: 6'd0, seconds: 6'd0};

  typedef struct packed {
    logic load;
    logic advance;
  } cal_ctl_t;

  typedef struct packed {
    logic command;
    cal_t load;
  } in_item_t;

  typedef struct packed {
    cal_t                cal;
    logic [TPS_W-1:0]    tick_in_second;
    logic [UPTIME_W-1:0] uptime;
    logic                second_pulse;
    logic                sync_request;
  } out_item_t;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  function automatic logic [4:0] days_of_month(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAYS_31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = DAYS_30;
      4'd2:                                      d = leap ? DAYS_29 : DAYS_28;
      default:                                   d = DAYS_31;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/tdcc_if.sv -----
// Valid/ready channel interfaces for the calendar clock: load/tick items in,
// calendar snapshots out. Depends on nothing.
interface tdcc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [13:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;
  logic [4:0]  load_hours;
  logic [5:0]  load_minutes;
  logic [5:0]  load_seconds;

  modport source (output valid, command, load_year, load_month, load_day, load_hours,
                  load_minutes, load_seconds, input ready);
  modport sink   (input valid, command, load_year, load_month, load_day, load_hours,
                  load_minutes, load_seconds, output ready);
endinterface

interface tdcc_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [19:0] tick_in_second;
  logic [63:0] uptime;
  logic        second_pulse;
  logic        sync_request;

  modport source (output valid, year, month, day, hours, minutes, seconds,
                  tick_in_second, uptime, second_pulse, sync_request, input ready);
  modport sink   (input valid, year, month, day, hours, minutes, seconds,
                  tick_in_second, uptime, second_pulse, sync_request, output ready);
endinterface

// ----- sv/tdcc_calendar.sv -----
// Calendar registers with one-second advance, Gregorian leap February and load.
// Depends on tdcc_pkg.
module tdcc_calendar import tdcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cal_ctl_t ctl,
  input  cal_t     load_val,
  output cal_t     cal_nxt
);

  cal_t        cal_r;
  logic [27:0] inv_prod;
  logic        mult25;
  logic        leap;
  logic [4:0]  dim;
  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [4:0]  mon_inc;
  cal_t        cal_adv;

  // divisible by 100 = by 4 and by 25; by 400 = by 16 and by 25
  assign inv_prod = cal_r.year * INV25_MOD14;
  assign mult25   = (inv_prod[13:0] <= MULT25_MAX);
  assign leap     = (cal_r.year[1:0] == 2'd0) && (!mult25 || (cal_r.year[3:0] == 4'd0));
  assign dim      = days_of_month(cal_r.month, leap);

  assign sec_inc  = {1'b0, cal_r.seconds} + 7'd1;
  assign min_inc  = {1'b0, cal_r.minutes} + 7'd1;
  assign hour_inc = {1'b0, cal_r.hours} + 6'd1;
  assign day_inc  = {1'b0, cal_r.day} + 6'd1;
  assign mon_inc  = {1'b0, cal_r.month} + 5'd1;

  always_comb begin
    cal_adv = cal_r;
    if (sec_inc < SECS_PER_MIN) begin
      cal_adv.seconds = sec_inc[5:0];
    end else begin
      cal_adv.seconds = '0;
      if (min_inc < MINS_PER_HOUR) begin
        cal_adv.minutes = min_inc[5:0];
      end else begin
        cal_adv.minutes = '0;
        if (hour_inc < HOURS_PER_DAY) begin
          cal_adv.hours = hour_inc[4:0];
        end else begin
          cal_adv.hours = '0;
          if (day_inc <= {1'b0, dim}) begin
            cal_adv.day = day_inc[4:0];
          end else begin
            cal_adv.day = 5'd1;
            if (mon_inc <= MONTHS) begin
              cal_adv.month = mon_inc[3:0];
            end else begin
              cal_adv.month = 4'd1;
              cal_adv.year  = cal_r.year + 14'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (ctl.load) begin
      cal_nxt = load_val;
    end else if (ctl.advance) begin
      cal_nxt = cal_adv;
    end else begin
      cal_nxt = cal_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= CAL_RESET;
    end else begin
      cal_r <= cal_nxt;
    end
  end

endmodule

// ----- sv/tdcc_core.sv -----
// Per-item step: sub-second, uptime and sync counters driving the calendar.
// Depends on tdcc_pkg and tdcc_calendar.
module tdcc_core import tdcc_pkg::*; #(
  parameter int TICK_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  in_item_t          item,
  input  logic [TPS_W-1:0]  tick_period,
  input  logic [SYNC_W-1:0] sync_interval,
  output out_item_t         result
);

  logic [TICK_BITS-1:0] sub_r, sub_nxt, sub_inc;
  logic [UPTIME_W-1:0]  uptime_r, uptime_nxt;
  logic [SYNC_W-1:0]    since_r, since_nxt, since_inc;
  logic                 is_tick;
  logic                 hit;
  logic                 pulse;
  logic                 sync;
  cal_ctl_t             cal_ctl;
  cal_t                 cal_nxt;

  assign is_tick   = (item.command == CMD_TICK);
  assign sub_inc   = sub_r + 1'b1;
  assign hit       = (sub_inc == TICK_BITS'(tick_period));
  assign pulse     = is_tick && hit;
  assign since_inc = since_r + 1'b1;
  assign sync      = pulse && (since_inc >= sync_interval);

  always_comb begin
    if (is_tick) begin
      sub_nxt    = hit ? '0 : sub_inc;
      uptime_nxt = uptime_r + 1'b1;
      if (pulse) begin
        since_nxt = sync ? '0 : since_inc;
      end else begin
        since_nxt = since_r;
      end
    end else begin
      sub_nxt    = sub_r;
      uptime_nxt = uptime_r;
      since_nxt  = '0;
    end
  end

  assign cal_ctl.load    = step_en && !is_tick;
  assign cal_ctl.advance = step_en && pulse;

  tdcc_calendar u_calendar (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cal_ctl),
    .load_val (item.load),
    .cal_nxt  (cal_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r    <= '0;
      uptime_r <= '0;
      since_r  <= '0;
    end else if (step_en) begin
      sub_r    <= sub_nxt;
      uptime_r <= uptime_nxt;
      since_r  <= since_nxt;
    end
  end

  assign result.cal            = cal_nxt;
  assign result.tick_in_second = TPS_W'(sub_nxt);
  assign result.uptime         = uptime_nxt;
  assign result.second_pulse   = pulse;
  assign result.sync_request   = sync;

endmodule

// ----- sv/tick_driven_calendar_clock_unit.sv -----
// Top level of the tick driven calendar clock: input register, step core,
// result register and configuration registers. Depends on tdcc_pkg, tdcc_if, tdcc_core.
//
//   channel  dir  handshake          carries
//   in_ch    in   valid/ready        command, load_year .. load_seconds
//   out_ch   out  valid/ready        year .. seconds, tick_in_second, uptime, flags
//   cfg_*    in   cfg_we only        cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ch.ready is high; results are registered.
// The step (counter compare cascade, leap test multiply, calendar rollover) sits
// between the input register and the result register.
// A stalled result holds in the result register while one more item waits in the
// input register; in_ch.ready drops only when both are full.
// Synchronous active-low reset: calendar 1970-01-01 00:00:00, counters zero.
module tick_driven_calendar_clock_unit import tdcc_pkg::*; #(
  parameter int TICK_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  tdcc_in_if.sink            in_ch,
  tdcc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_wdata
);

  logic [TPS_W-1:0]  tps_r;
  logic [SYNC_W-1:0] sync_ival_r;
  logic              in_valid_r;
  in_item_t          in_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  out_item_t         step_result;
  logic              adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= TPS_RESET;
      sync_ival_r <= SYNC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_PERIOD:   tps_r       <= cfg_wdata[TPS_W-1:0];
        REG_SYNC_INTERVAL: sync_ival_r <= cfg_wdata[SYNC_W-1:0];
        default: ;
      endcase
    end
  end

  // item moves from the input register to the result register
  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.command      <= in_ch.command;
      in_item_r.load.year    <= in_ch.load_year;
      in_item_r.load.month   <= in_ch.load_month;
      in_item_r.load.day     <= in_ch.load_day;
      in_item_r.load.hours   <= in_ch.load_hours;
      in_item_r.load.minutes <= in_ch.load_minutes;
      in_item_r.load.seconds <= in_ch.load_seconds;
    end
  end

  tdcc_core #(.TICK_BITS(TICK_BITS)) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (adv),
    .item             (in_item_r),
    .tick_period      (tps_r),
    .sync_interval    (sync_ival_r),
    .result           (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= step_result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.year           = out_item_r.cal.year;
  assign out_ch.month          = out_item_r.cal.month;
  assign out_ch.day            = out_item_r.cal.day;
  assign out_ch.hours          = out_item_r.cal.hours;
  assign out_ch.minutes        = out_item_r.cal.minutes;
  assign out_ch.seconds        = out_item_r.cal.seconds;
  assign out_ch.tick_in_second = out_item_r.tick_in_second;
  assign out_ch.uptime         = out_item_r.uptime;
  assign out_ch.second_pulse   = out_item_r.second_pulse;
  assign out_ch.sync_request   = out_item_r.sync_request;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_item_r))
    else $error("input register lost a waiting item");

  a_sync_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.sync_request |-> out_item_r.second_pulse)
    else $error("sync request without a completed second");

  a_pulse_clears_sub: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.second_pulse |-> out_item_r.tick_in_second == '0)
    else $error("second completed but sub-second count not cleared");

  a_load_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_item_r.command == CMD_LOAD)
      |=> !out_item_r.second_pulse && !out_item_r.sync_request)
    else $error("load item raised a pulse flag");

endmodule

// ----- verif/tick_driven_calendar_clock_unit_tb.sv -----
// Self-checking testbench for tick_driven_calendar_clock_unit: tick/load items in,
// calendar snapshots out, checked against an in-bench calendar predictor.
// Depends on tdcc_pkg, tdcc_if and the unit's RTL.
module tick_driven_calendar_clock_unit_tb;
  import tdcc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  tdcc_in_if  in_ch();
  tdcc_out_if out_ch();

  tick_driven_calendar_clock_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor copy of configuration and clock state
  logic [TPS_W-1:0]    tps_reg;
  logic [SYNC_W-1:0]   sync_reg;
  logic [TPS_W-1:0]    sub_ticks;
  logic [UPTIME_W-1:0] uptime_cnt;
  logic [SYNC_W-1:0]   secs_since_sync;
  cal_t                cal_now;

  in_item_t  pending_items[$];
  out_item_t expected_snapshots[$];
  in_item_t  offered;
  bit        offer_open = 1'b0;
  bit        out_hold = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mismatches = 0;
  int        results_seen = 0;

  function automatic int month_length(input int mo, input int yr);
    bit leap;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mo)
      4, 6, 9, 11: return 30;
      2:           return leap ? 29 : 28;
      default:     return 31;  // also months 0 and 13..15
    endcase
  endfunction

  function automatic out_item_t calendar_step(input in_item_t it);
    out_item_t r;
    int n;
    bit carry;
    r.second_pulse = 1'b0;
    r.sync_request = 1'b0;
    if (it.command == CMD_LOAD) begin
      cal_now = it.load;
      secs_since_sync = '0;
    end else begin
      uptime_cnt = uptime_cnt + 64'd1;
      sub_ticks = sub_ticks + 1'b1;
      if (sub_ticks == tps_reg) begin
        sub_ticks = '0;
        r.second_pulse = 1'b1;
        secs_since_sync = secs_since_sync + 1'b1;
        // carry cascade; out-of-range fields roll over on the first carry into them
        n = int'(cal_now.seconds) + 1;
        carry = (n >= 60);
        cal_now.seconds = carry ? 6'd0 : 6'(n);
        if (carry) begin
          n = int'(cal_now.minutes) + 1;
          carry = (n >= 60);
          cal_now.minutes = carry ? 6'd0 : 6'(n);
        end
        if (carry) begin
          n = int'(cal_now.hours) + 1;
          carry = (n >= 24);
          cal_now.hours = carry ? 5'd0 : 5'(n);
        end
        if (carry) begin
          n = int'(cal_now.day) + 1;
          carry = (n > month_length(int'(cal_now.month), int'(cal_now.year)));
          cal_now.day = carry ? 5'd1 : 5'(n);
        end
        if (carry) begin
          n = int'(cal_now.month) + 1;
          carry = (n > 12);
          cal_now.month = carry ? 4'd1 : 4'(n);
        end
        if (carry) cal_now.year = cal_now.year + 1'b1;
        if (secs_since_sync >= sync_reg) begin
          secs_since_sync = '0;
          r.sync_request = 1'b1;
        end
      end
    end
    r.cal = cal_now;
    r.tick_in_second = sub_ticks;
    r.uptime = uptime_cnt;
    return r;
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it = random_item();  // load fields carry junk, ignored on a tick
    it.command = CMD_TICK;
    return it;
  endfunction

  function automatic in_item_t near_rollover_load();
    in_item_t it;
    int yr, mo;
    case ($urandom_range(4))
      0:       yr = $urandom_range(16383);
      1:       yr = 100 * $urandom_range(163);
      2:       yr = 4 * $urandom_range(4095);
      3:       yr = 16383;
      default: yr = 1996 + $urandom_range(8);
    endcase
    case ($urandom_range(3))
      0:       mo = 2;
      1:       mo = 12;
      default: mo = $urandom_range(12, 1);
    endcase
    it.command = CMD_LOAD;
    it.load.year = 14'(yr);
    it.load.month = 4'(mo);
    it.load.day = 5'(month_length(mo, yr) - $urandom_range(1));
    it.load.hours = ($urandom_range(3) == 0) ? 5'($urandom_range(23)) : 5'd23;
    it.load.minutes = ($urandom_range(3) == 0) ? 6'($urandom_range(59)) : 6'd59;
    it.load.seconds = ($urandom_range(3) == 0) ? 6'($urandom_range(59))
                                               : 6'(59 - $urandom_range(1));
    return it;
  endfunction

  task automatic queue_item(input in_item_t it);
    while (pending_items.size() >= 64) @(negedge clk);
    pending_items.push_back(it);
  endtask

  task automatic load_then_tick(input int yr, input int mo, input int dy,
                                input int hr, input int mn, input int sc);
    in_item_t it;
    it.command = CMD_LOAD;
    it.load.year = 14'(yr);
    it.load.month = 4'(mo);
    it.load.day = 5'(dy);
    it.load.hours = 5'(hr);
    it.load.minutes = 6'(mn);
    it.load.seconds = 6'(sc);
    queue_item(it);
    queue_item(tick_item());
  endtask

  // block is empty once every expected snapshot is back; a few extra cycles for margin
  task automatic wait_idle();
    while (pending_items.size() != 0 || offer_open || expected_snapshots.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_TICK_PERIOD) tps_reg = val[TPS_W-1:0];
    else sync_reg = val[SYNC_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
    int done, burst;
    wait_idle();
    write_reg(REG_TICK_PERIOD, ($urandom_range(3) == 0) ? $urandom_range(40, 5)
                                                        : $urandom_range(3, 1));
    case ($urandom_range(5))
      0:       write_reg(REG_SYNC_INTERVAL, 0);
      1:       write_reg(REG_SYNC_INTERVAL, 4095);
      default: write_reg(REG_SYNC_INTERVAL, $urandom_range(4, 1));
    endcase
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 85) begin
        // load near a rollover, then a random burst of ticks that can cross it
        queue_item(near_rollover_load());
        burst = $urandom_range(2 * int'(tps_reg) + 3, 1);
        repeat (burst) queue_item(tick_item());
        done += burst + 1;
      end else begin
        queue_item(random_item());
        done++;
      end
    end
  endtask

  // sender: next item offered at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!offer_open) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_items.pop_front();
        in_ch.command <= offered.command;
        in_ch.load_year <= offered.load.year;
        in_ch.load_month <= offered.load.month;
        in_ch.load_day <= offered.load.day;
        in_ch.load_hours <= offered.load.hours;
        in_ch.load_minutes <= offered.load.minutes;
        in_ch.load_seconds <= offered.load.seconds;
        in_ch.valid <= 1'b1;
        offer_open = 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    out_ch.ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    out_item_t got, want;
    string diffs;
    if (in_ch.valid && in_ch.ready) begin
      expected_snapshots.push_back(calendar_step(offered));
      offer_open = 1'b0;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cal.year = out_ch.year;
      got.cal.month = out_ch.month;
      got.cal.day = out_ch.day;
      got.cal.hours = out_ch.hours;
      got.cal.minutes = out_ch.minutes;
      got.cal.seconds = out_ch.seconds;
      got.tick_in_second = out_ch.tick_in_second;
      got.uptime = out_ch.uptime;
      got.second_pulse = out_ch.second_pulse;
      got.sync_request = out_ch.sync_request;
      if (expected_snapshots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with no item outstanding", results_seen);
      end else begin
        want = expected_snapshots.pop_front();
        diffs = "";
        if (got.cal.year !== want.cal.year)
          diffs = {diffs, $sformatf(" year %0d/%0d", want.cal.year, got.cal.year)};
        if (got.cal.month !== want.cal.month)
          diffs = {diffs, $sformatf(" month %0d/%0d", want.cal.month, got.cal.month)};
        if (got.cal.day !== want.cal.day)
          diffs = {diffs, $sformatf(" day %0d/%0d", want.cal.day, got.cal.day)};
        if (got.cal.hours !== want.cal.hours)
          diffs = {diffs, $sformatf(" hours %0d/%0d", want.cal.hours, got.cal.hours)};
        if (got.cal.minutes !== want.cal.minutes)
          diffs = {diffs, $sformatf(" minutes %0d/%0d", want.cal.minutes, got.cal.minutes)};
        if (got.cal.seconds !== want.cal.seconds)
          diffs = {diffs, $sformatf(" seconds %0d/%0d", want.cal.seconds, got.cal.seconds)};
        if (got.tick_in_second !== want.tick_in_second)
          diffs = {diffs, $sformatf(" tick_in_second %0d/%0d",
                                    want.tick_in_second, got.tick_in_second)};
        if (got.uptime !== want.uptime)
          diffs = {diffs, $sformatf(" uptime %0d/%0d", want.uptime, got.uptime)};
        if (got.second_pulse !== want.second_pulse)
          diffs = {diffs, $sformatf(" second_pulse %0b/%0b",
                                    want.second_pulse, got.second_pulse)};
        if (got.sync_request !== want.sync_request)
          diffs = {diffs, $sformatf(" sync_request %0b/%0b",
                                    want.sync_request, got.sync_request)};
        if (diffs != "") begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d differs (expected/actual):%s", results_seen, diffs);
        end
      end
      results_seen++;
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TICK_PERIOD;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.load_year = '0;
    in_ch.load_month = '0;
    in_ch.load_day = '0;
    in_ch.load_hours = '0;
    in_ch.load_minutes = '0;
    in_ch.load_seconds = '0;
    out_ch.ready = 1'b0;
    tps_reg = 20'd1000;
    sync_reg = 12'd3600;
    sub_ticks = '0;
    uptime_cnt = '0;
    secs_since_sync = '0;
    cal_now = '{year: 14'd1970, month: 4'd1, day: 5'd1,
                hours: 5'd0, minutes: 6'd0, seconds: 6'd0};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, then one second per tick across calendar corners
    queue_item(tick_item());
    queue_item(tick_item());
    wait_idle();
    write_reg(REG_TICK_PERIOD, 1);
    write_reg(REG_SYNC_INTERVAL, 1);
    load_then_tick(9999, 12, 31, 23, 59, 59);
    load_then_tick(16383, 12, 31, 23, 59, 59);  // year wraps to 0
    load_then_tick(2000, 2, 28, 23, 59, 59);
    load_then_tick(1900, 2, 28, 23, 59, 59);
    load_then_tick(2024, 2, 29, 23, 59, 59);
    load_then_tick(2023, 2, 28, 23, 59, 59);
    load_then_tick(2023, 6, 31, 23, 59, 59);
    load_then_tick(0, 0, 31, 31, 63, 63);       // month 0 acts as 31 days
    load_then_tick(2023, 15, 0, 24, 60, 60);
    load_then_tick(2023, 13, 31, 23, 59, 59);
    load_then_tick(0, 0, 0, 0, 0, 0);

    run_phase(0, 0, 250);
    run_phase(71, 0, 250);
    run_phase(0, 71, 250);
    run_phase(30, 30, 250);

    // receiver holds off while the sender keeps offering, so the input backs up
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        out_hold = 1'b1;
        repeat (300) @(posedge clk);
        out_hold = 1'b0;
      end
    join_none
    repeat (40) queue_item(tick_item());

    // longest sync interval stays unreached, then lowered below the running count, then zero
    wait_idle();
    write_reg(REG_TICK_PERIOD, 1);
    write_reg(REG_SYNC_INTERVAL, 4095);
    load_then_tick(2099, 12, 31, 23, 59, 59);
    repeat (40) queue_item(tick_item());
    wait_idle();
    write_reg(REG_SYNC_INTERVAL, 2);
    repeat (6) queue_item(tick_item());
    wait_idle();
    write_reg(REG_SYNC_INTERVAL, 0);
    repeat (4) queue_item(tick_item());

    // widest tick period, then zero below the running count: no second completes
    wait_idle();
    write_reg(REG_TICK_PERIOD, 20'hFFFFF);
    write_reg(REG_SYNC_INTERVAL, 1);
    repeat (40) queue_item(tick_item());
    wait_idle();
    write_reg(REG_TICK_PERIOD, 0);
    repeat (5) queue_item(tick_item());

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tdcc_pkg.sv
sv/tdcc_if.sv
sv/tdcc_calendar.sv
sv/tdcc_core.sv
sv/tick_driven_calendar_clock_unit.sv
verif/tick_driven_calendar_clock_unit_tb.sv
